FILE: design/otft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otft_pkg
// Shared types and constants for the OOK frame transmitter.
// ----------------------------------------------------------------------------
package otft_pkg;

  localparam int unsigned VALUE_BITS     = 10;
  localparam int unsigned SYNC_LOW_SLOTS = 10;
  localparam int unsigned GAP_PAIRS      = 20;

  localparam int unsigned FRAME_W   = 32;
  localparam int unsigned SYNC_LEN  = 1 + SYNC_LOW_SLOTS;
  localparam int unsigned DATA_LEN  = 8 * FRAME_W;
  localparam int unsigned HIGH_SLOT = SYNC_LEN + DATA_LEN;
  localparam int unsigned PASS_LEN  = HIGH_SLOT + 1 + 2 * GAP_PAIRS;
  localparam int unsigned SLOT_W    = $clog2(PASS_LEN);

  localparam int unsigned NODE_W  = 2;
  localparam int unsigned REPT_W  = 4;
  localparam int unsigned VALIN_W = 10;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned CFG_W   = 4;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_NODE_ID      = 1'b0,
    REG_REPEAT_COUNT = 1'b1
  } cfg_reg_e;

  // Command handed from the front end to the sequencer
  typedef struct packed {
    logic               is_start;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic last;
  } res_t;

endpackage

FILE: design/ook_rf_frame_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_rf_frame_transmitter
// On-off keyed frame transmitter: start items load a frame, tick items step
// the line one half-period slot at a time.
// ----------------------------------------------------------------------------
// Takes one item per clock while full is low. A start produces no result;
// each tick produces one result, which is registered in the command queue
// and then in the output queue before it reaches the result ports. The slot
// sequencer retires one queued command per cycle while the output queue has
// room for a tick, so full only rises when the result side is not being drained.
// One pass is 308 slots, stepped one slot per tick by a slot and a pass counter.
// node_id is latched into the frame at start; repeat_count is read live.
module ook_rf_frame_transmitter
  import otft_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               op_i,
  input  logic [VALIN_W-1:0] value_i,
  input  logic [CHAN_W-1:0]  channel_i,
  output logic               empty,
  input  logic               pop,
  output logic               line_level_o,
  output logic               busy_res_o,
  output logic               last_slot_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_addr_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  otft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .op_i        (op_i),
    .value_i     (value_i),
    .channel_i   (channel_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  otft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign line_level_o = res.line_level;
  assign busy_res_o   = res.busy;
  assign last_slot_o  = res.last;

endmodule

FILE: design/otft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otft_front
// Accepts items, decodes the operation, assembles the frame word for a start
// and queues the resulting command for the sequencer.
// ----------------------------------------------------------------------------
module otft_front
  import otft_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                op_i,
  input  logic [VALIN_W-1:0]  value_i,
  input  logic [CHAN_W-1:0]   channel_i,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_addr_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_pop_i
);

  // Frame word bit 31-p holds frame bit p (bit 0 goes out first)
  function automatic logic [FRAME_W-1:0] build_frame(logic [NODE_W-1:0] node,
                                                     logic [VALIN_W-1:0] val,
                                                     logic [CHAN_W-1:0] chan);
    logic [FRAME_W-1:0] f;
    logic [15:0]        v;
    f = '1;
    v = 16'(val);
    f[4]  = 1'b0;
    f[23] = ~node[1];
    f[22] = ~node[0];
    for (int i = 0; i < VALUE_BITS; i++) begin
      f[6+i] = ~v[i];
    end
    f[CHAN_W-1:0] = ~chan;
    return f;
  endfunction

  logic [NODE_W-1:0] node_id_q;
  cmd_t              mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              acc;
  cmd_t              new_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= NODE_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_NODE_ID: node_id_q <= cfg_wdata_i[NODE_W-1:0];
        default:     ;
      endcase
    end
  end

  assign full_o = (cnt_q == 2'd2);
  assign acc    = push_i && !full_o;

  always_comb begin
    new_cmd.is_start = (op_e'(op_i) == OP_START);
    new_cmd.frame    = build_frame(node_id_q, value_i, channel_i);
  end

  always_comb begin
    cnt_d = cnt_q;
    case ({acc, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (acc)       wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem_q[wr_ptr_q] <= new_cmd;
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];

endmodule

FILE: design/otft_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otft_back
// Slot sequencer: loads a frame on start, emits one line slot per tick and
// holds results in a two-entry output queue.
// ----------------------------------------------------------------------------
module otft_back
  import otft_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output res_t             res_o
);

  logic [REPT_W-1:0]  rep_cnt_q;
  logic               active_q, active_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [REPT_W-1:0]  rep_q, rep_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  res_t               res_new;
  logic               res_push, res_pop;
  res_t               oq_q [2];
  logic               oq_wr_q, oq_rd_q;
  logic [1:0]         oq_cnt_q, oq_cnt_d;
  logic [SLOT_W-1:0]  k;
  logic [4:0]         bitpos;
  logic [2:0]         ph;
  logic               bit_val, level;
  logic [REPT_W-1:0]  want;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_cnt_q <= REPT_W'(5);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_REPEAT_COUNT: rep_cnt_q <= cfg_wdata_i[REPT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Starts never need an output slot; ticks wait for room
  assign cmd_pop_o = cmd_valid_i && (cmd_i.is_start || oq_cnt_q != 2'd2);
  assign res_push  = cmd_pop_o && !cmd_i.is_start;
  assign res_pop   = pop_i && !empty_o;

  // Line level for the current slot
  always_comb begin
    k       = slot_q - SLOT_W'(SYNC_LEN);
    bitpos  = k[7:3];
    ph      = k[2:0];
    bit_val = frame_q[~bitpos];
    if (slot_q == '0) begin
      level = 1'b1;
    end else if (slot_q < SLOT_W'(SYNC_LEN)) begin
      level = 1'b0;
    end else if (slot_q < SLOT_W'(HIGH_SLOT)) begin
      if (ph == 3'd0)   level = 1'b1;
      else if (bit_val) level = (ph == 3'd2);
      else              level = (ph == 3'd6);
    end else begin
      level = (slot_q == SLOT_W'(HIGH_SLOT));
    end
  end

  always_comb begin
    want     = (rep_cnt_q == '0) ? REPT_W'(1) : rep_cnt_q;
    active_d = active_q;
    slot_d   = slot_q;
    rep_d    = rep_q;
    frame_d  = frame_q;
    res_new  = '0;
    if (cmd_pop_o) begin
      if (cmd_i.is_start) begin
        if (!active_q) begin
          frame_d  = cmd_i.frame;
          slot_d   = '0;
          rep_d    = '0;
          active_d = 1'b1;
        end
      end else if (active_q) begin
        res_new.busy       = 1'b1;
        res_new.line_level = level;
        if (slot_q == SLOT_W'(PASS_LEN - 1)) begin
          slot_d = '0;
          if ({1'b0, rep_q} + 5'd1 >= {1'b0, want}) begin
            res_new.last = 1'b1;
            active_d     = 1'b0;
            rep_d        = '0;
          end else begin
            rep_d = rep_q + REPT_W'(1);
          end
        end else begin
          slot_d = slot_q + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      slot_q   <= '0;
      rep_q    <= '0;
      frame_q  <= '0;
    end else begin
      active_q <= active_d;
      slot_q   <= slot_d;
      rep_q    <= rep_d;
      frame_q  <= frame_d;
    end
  end

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    case ({res_push, res_pop})
      2'b10:   oq_cnt_d = oq_cnt_q + 2'd1;
      2'b01:   oq_cnt_d = oq_cnt_q - 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (res_push) oq_wr_q <= ~oq_wr_q;
      if (res_pop)  oq_rd_q <= ~oq_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      oq_q[oq_wr_q] <= res_new;
    end
  end

  assign empty_o = (oq_cnt_q == 2'd0);
  assign res_o   = oq_q[oq_rd_q];

endmodule

FILE: design/otft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otft_checker
// Port-level checks for the OOK frame transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module otft_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic pop,
  input logic empty,
  input logic line_level_o,
  input logic busy_res_o,
  input logic last_slot_o
);

  // Final slot of a transmission is always part of it
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (!last_slot_o || busy_res_o))
    else $error("last slot without busy");

  // Idle slots drive the line low
  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !busy_res_o) |-> !line_level_o)
    else $error("line high while idle");

  // The final slot is the gap, always low
  a_last_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_slot_o) |-> !line_level_o)
    else $error("final slot not low");

  // A waiting result holds until its transfer
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(line_level_o) && $stable(busy_res_o)
                          && $stable(last_slot_o)))
    else $error("result changed while stalled");

endmodule

bind ook_rf_frame_transmitter otft_checker u_otft_checker (.*);

FILE: dv/ook_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_frame_checker
// Watches the item, result and register ports of the OOK frame transmitter,
// predicts the line slot of every tick transfer and compares it, field by
// field, with the results that leave the block in order.
// ----------------------------------------------------------------------------
module ook_frame_checker
  import otft_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic               op_i,
  input  logic [VALIN_W-1:0] value_i,
  input  logic [CHAN_W-1:0]  channel_i,
  input  logic               empty,
  input  logic               pop,
  input  logic               line_level_o,
  input  logic               busy_res_o,
  input  logic               last_slot_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_addr_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output int unsigned        n_errors,
  output int unsigned        n_pending
);

  // One pass: sync high + 10 low, 32 bits of 8 slots, a high slot, 40 low slots
  localparam int unsigned SyncSlots = 11;
  localparam int unsigned HighSlot  = SyncSlots + 256;
  localparam int unsigned PassSlots = HighSlot + 1 + 40;
  localparam int unsigned PrintCap  = 40;

  logic [31:0] tx_frame   = '0;
  logic [8:0]  slot       = '0;
  logic [3:0]  pass_idx   = '0;
  logic        sending    = 1'b0;
  logic [1:0]  node_id_q  = 2'd2;
  logic [3:0]  repeats_q  = 4'd5;

  res_t        slot_q[$];
  int unsigned errs       = 0;
  int unsigned waiting    = 0;
  int unsigned n_results  = 0;

  assign n_errors  = errs;
  assign n_pending = waiting;

  task automatic report_mismatch(input string what);
    if (errs < PrintCap) begin
      $display("[%0t] ook_frame_checker: %s", $time, what);
    end
    errs++;
  endtask

  // Word bit 31-n holds frame bit n, so the first bit sent is the MSB
  function automatic logic [31:0] frame_word(input logic [1:0] node,
                                             input logic [VALIN_W-1:0] v,
                                             input logic [CHAN_W-1:0] ch);
    logic [31:0] w;
    w       = '1;
    w[23]   = ~node[1];
    w[22]   = ~node[0];
    w[15:6] = ~v;
    w[4]    = 1'b0;
    w[3:0]  = ~ch;
    return w;
  endfunction

  function automatic logic level_at(input logic [31:0] w, input int unsigned s);
    int unsigned k;
    logic [2:0]  ph;
    logic        b;
    if (s == 0) return 1'b1;
    if (s < SyncSlots) return 1'b0;
    if (s < HighSlot) begin
      k  = s - SyncSlots;
      ph = k[2:0];
      b  = w[31 - k / 8];
      if (ph == 3'd0) return 1'b1;
      return b ? (ph == 3'd2) : (ph == 3'd6);
    end
    return s == HighSlot;
  endfunction

  task automatic predict_tick(output res_t r);
    int unsigned passes;
    r = '0;
    if (!sending) return;
    r.busy       = 1'b1;
    r.line_level = level_at(tx_frame, slot);
    if (slot + 1 >= PassSlots) begin
      passes = (repeats_q == 4'd0) ? 1 : repeats_q;
      slot   = '0;
      if (pass_idx + 1 >= passes) begin
        r.last   = 1'b1;
        sending  = 1'b0;
        pass_idx = '0;
      end else begin
        pass_idx = pass_idx + 4'd1;
      end
    end else begin
      slot = slot + 9'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      tx_frame  = '0;
      slot      = '0;
      pass_idx  = '0;
      sending   = 1'b0;
      node_id_q = 2'd2;
      repeats_q = 4'd5;
      slot_q.delete();
      waiting   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_NODE_ID:      node_id_q = cfg_wdata_i[1:0];
          REG_REPEAT_COUNT: repeats_q = cfg_wdata_i[3:0];
          default: ;
        endcase
      end

      if (push && !full) begin
        if (op_e'(op_i) == OP_TICK) begin
          predict_tick(want);
          slot_q.push_back(want);
        end else if (!sending) begin
          // node id is latched here; a start while sending is dropped
          tx_frame = frame_word(node_id_q, value_i, channel_i);
          slot     = '0;
          pass_idx = '0;
          sending  = 1'b1;
        end
      end

      if (pop && !empty) begin
        n_results++;
        if (slot_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none outstanding",
                                    n_results));
        end else begin
          want = slot_q.pop_front();
          if (line_level_o !== want.line_level)
            report_mismatch($sformatf("result %0d: line_level %b, want %b",
                                      n_results, line_level_o, want.line_level));
          if (busy_res_o !== want.busy)
            report_mismatch($sformatf("result %0d: busy_res %b, want %b",
                                      n_results, busy_res_o, want.busy));
          if (last_slot_o !== want.last)
            report_mismatch($sformatf("result %0d: last_slot %b, want %b",
                                      n_results, last_slot_o, want.last));
        end
      end
      waiting = slot_q.size();
    end
  end

endmodule

FILE: dv/tb_ook_rf_frame_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ook_rf_frame_transmitter
// Drives start and tick items into the OOK frame transmitter with random
// gaps and result-side stalls, rewrites node id and repeat count between
// phases, and leaves all prediction and comparison to ook_frame_checker.
// ----------------------------------------------------------------------------
module tb_ook_rf_frame_transmitter;
  import otft_pkg::*;

  localparam int unsigned TickTarget    = 950;
  localparam int unsigned CalmFrom      = 800;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned WatchdogLimit = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic               op_i;
  logic [VALIN_W-1:0] value_i;
  logic [CHAN_W-1:0]  channel_i;
  logic               empty;
  logic               pop;
  logic               line_level_o;
  logic               busy_res_o;
  logic               last_slot_o;
  logic               cfg_we_i;
  logic [0:0]         cfg_addr_i;
  logic [CFG_W-1:0]   cfg_wdata_i;

  int unsigned n_errors;
  int unsigned n_pending;
  int unsigned n_ticks   = 0;
  int unsigned send_calm = 0;
  bit          no_idle   = 1'b0;
  bit          hold_req  = 1'b0;

  ook_rf_frame_transmitter i_dut (.*);

  ook_frame_checker i_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin : drain
    int unsigned stall;
    int unsigned calm;
    stall = 0;
    calm  = 0;
    pop   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        pop <= 1'b0;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        pop   <= 1'b0;
        stall = HoldCycles - 1;
      end else if (no_idle) begin
        pop <= 1'b1;
      end else if (calm > 0) begin
        pop <= 1'b1;
        calm--;
      end else if ($urandom_range(0, 39) == 0) begin
        pop <= 1'b1;
        calm = $urandom_range(20, 60);
      end else if ($urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(1, 13) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("tb_ook_rf_frame_transmitter: errors");
    $finish;
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Returns at the edge of the transfer with push still high
  task automatic send(input op_e op, input logic [VALIN_W-1:0] v,
                      input logic [CHAN_W-1:0] ch);
    if (!no_idle) begin
      if (send_calm > 0) begin
        send_calm--;
      end else if ($urandom_range(0, 39) == 0) begin
        send_calm = $urandom_range(20, 60);
      end else if ($urandom_range(0, 7) == 0) begin
        push      <= 1'b0;
        op_i      <= 1'($urandom_range(0, 1));
        value_i   <= VALIN_W'($urandom_range(0, 1023));
        channel_i <= CHAN_W'($urandom_range(0, 15));
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
    push      <= 1'b1;
    op_i      <= op;
    value_i   <= v;
    channel_i <= ch;
    do @(posedge clk_i); while (full);
    if (op == OP_TICK) n_ticks++;
  endtask

  task automatic tick();
    send(OP_TICK, VALIN_W'($urandom_range(0, 1023)), CHAN_W'($urandom_range(0, 15)));
  endtask

  // Everything outstanding has left, then a settle wait for a trailing start
  task automatic settle();
    do @(negedge clk_i); while (n_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] pick_repeats();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'd15;
      2:       return 4'd2;
      3:       return CFG_W'($urandom_range(3, 14));
      default: return 4'd1;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned len;
    logic [VALIN_W-1:0] v;
    logic [CHAN_W-1:0]  ch;

    rst_ni      = 1'b0;
    push        = 1'b0;
    op_i        = OP_TICK;
    value_i     = '0;
    channel_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = REG_NODE_ID;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle tick straight after reset
    send(OP_TICK, 10'h3FF, 4'hF);
    push <= 1'b0;
    settle();

    write_reg(REG_NODE_ID, 4'd0);
    write_reg(REG_REPEAT_COUNT, 4'd0);
    send(OP_START, 10'h000, 4'hF);
    repeat (6) tick();
    send(OP_START, 10'h3FF, 4'h0);   // dropped: frame in flight
    repeat (4) tick();
    push <= 1'b0;
    settle();

    // Node id must not touch the frame in flight; repeat count is live
    write_reg(REG_NODE_ID, 4'hF);
    write_reg(REG_REPEAT_COUNT, 4'd15);
    repeat (4) tick();
    push <= 1'b0;
    settle();

    phase = 0;
    while (n_ticks < TickTarget) begin
      phase++;
      no_idle = (n_ticks >= CalmFrom);
      if ($urandom_range(0, 1) == 0 || phase == 1)
        write_reg(REG_NODE_ID, CFG_W'($urandom_range(0, 15)));
      write_reg(REG_REPEAT_COUNT, pick_repeats());
      len = $urandom_range(20, 250);
      if (phase == 3) begin
        hold_req = 1'b1;
        len = 150;
      end
      if (len > TickTarget - n_ticks) len = TickTarget - n_ticks;
      for (int unsigned i = 0; i < len; i++) begin
        if ((i == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 59) == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            v  = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
            ch = $urandom_range(0, 1) ? 4'hF : 4'h0;
          end else begin
            v  = VALIN_W'($urandom_range(0, 1023));
            ch = CHAN_W'($urandom_range(0, 15));
          end
          send(OP_START, v, ch);
        end else begin
          tick();
        end
      end
      push <= 1'b0;
      settle();
    end

    no_idle = 1'b1;
    repeat (8) @(posedge clk_i);
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb_ook_rf_frame_transmitter: clean");
    end else begin
      $display("tb_ook_rf_frame_transmitter: errors");
    end
    $finish;
  end

endmodule
